### hw/rtl/clock_page_replacement_defines.svh
// Assertion macros shared by the clock page replacement RTL.
// Each check is clocked on the rising edge and is switched off while reset is high.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define CPR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clock page replacement check failed");
// The consequent must hold in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clock page replacement check failed");
`else
`define CPR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/cpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // Field widths of the items and of the register.
  localparam int FRAME_W       = 8;
  localparam int FRAME_COUNT_W = 9;

  // Largest value the frame count register can hold.
  localparam int FRAME_COUNT_MAX = 2 ** FRAME_COUNT_W - 1;

  // Default number of frames the design is built for.
  localparam int MAX_FRAMES_DEFAULT = 256;

  // Frame count after reset.
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = FRAME_COUNT_W'(256);

  // Operation codes of an input item.
  localparam logic OP_REF   = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  // Result offered by the core to the output register.
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] victim;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/cpr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one item per page reference or eviction request.
interface cpr_req_if import cpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [FRAME_W-1:0] frame_index;

  modport source (output valid, output op, output frame_index, input ready);
  modport sink (input valid, input op, input frame_index, output ready);
endinterface

// Response channel: one item per eviction request.
interface cpr_rsp_if import cpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] victim_frame;

  modport source (output valid, output victim_frame, input ready);
  modport sink (input valid, input victim_frame, output ready);
endinterface

// Configuration write channel for the frame count register.
interface cpr_cfg_if import cpr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRAME_COUNT_W-1:0] frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink (input valid, input frame_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/clock_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// CLOCK (second-chance) page replacement over up to MAX_FRAMES frames, with the number
// of active frames set by the frame count register. A reference item produces no result.
// An eviction item reads the bit under the hand and then walks on frame by frame,
// clearing each set reference bit that it passes, until it finds the victim; it examines
// at most the active frame count plus one frames. The walk is paced by the
// single read port of the reference bit memory, which the walk reads one frame a cycle.
// After reset the block clears its reference bit memory, one entry a cycle, over
// min(MAX_FRAMES, 256) entries, and accepts no item until that pass is done.
module clock_page_replacement import cpr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  cpr_cfg_if.sink  cfg,
  cpr_req_if.sink  req,
  cpr_rsp_if.source rsp
);

  localparam int N_LIMIT = (MAX_FRAMES < FRAME_COUNT_MAX) ? MAX_FRAMES : FRAME_COUNT_MAX;
  localparam int CNT_W   = $clog2(N_LIMIT + 1);

  // Frame count as used by the clock: zero means one, large values saturate.
  function automatic logic [CNT_W-1:0] active_count(input logic [FRAME_COUNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (int'(v) > N_LIMIT) begin
      return CNT_W'(N_LIMIT);
    end else begin
      return CNT_W'(v);
    end
  endfunction

  logic [CNT_W-1:0]   n;
  logic               out_valid;
  logic [FRAME_W-1:0] out_victim;
  logic               res_taken;
  result_t            res;

  // Configuration register, always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= active_count(FRAME_COUNT_RESET);
    end else if (cfg.valid) begin
      n <= active_count(cfg.frame_count);
    end
  end

  cpr_core #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .req       (req),
    .res_taken (res_taken),
    .res       (res)
  );

  // Output register: the slot is free when empty or being drained this cycle.
  assign res_taken = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken && res.valid) begin
      out_victim <= res.victim;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.victim_frame = out_victim;

endmodule

`default_nettype wire

### hw/rtl/cpr_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "clock_page_replacement_defines.svh"

module cpr_core import cpr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT,
  localparam int N_LIMIT   = (MAX_FRAMES < FRAME_COUNT_MAX) ? MAX_FRAMES : FRAME_COUNT_MAX,
  localparam int CNT_W     = $clog2(N_LIMIT + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] n,
  cpr_req_if.sink               req,
  input  wire logic             res_taken,
  output result_t               res
);

  // Only frames below 2**FRAME_W can ever be referenced, so only those need storage.
  localparam int MEM_DEPTH = (MAX_FRAMES < 2 ** FRAME_W) ? MAX_FRAMES : 2 ** FRAME_W;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int HAND_W    = $clog2(N_LIMIT);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  // Next position of the hand with wraparound.
  function automatic logic [HAND_W-1:0] next_slot(input logic [HAND_W-1:0] p,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] s;
    s = CNT_W'(p) + CNT_W'(1);
    return (s >= cnt) ? '0 : HAND_W'(s);
  endfunction

  // Frames at or above the storage depth always read as clear.
  function automatic logic beyond_mem(input logic [HAND_W-1:0] p);
    return CNT_W'(p) >= CNT_W'(MEM_DEPTH);
  endfunction

  logic [1:0]        state, state_next;
  logic [HAND_W-1:0] hand, hand_next;
  logic              fill_done, fill_done_next;
  logic [HAND_W-1:0] cur, cur_next;
  logic [MEM_AW-1:0] clr_addr;
  logic              rd_zero, rd_zero_next;

  logic              mem [MEM_DEPTH];
  logic              rd_data;
  logic              mem_we, mem_wdata, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;

  logic [HAND_W-1:0] pos, pos_adv, cur_adv;
  logic              walk_bit, req_fire;

  // Reference bit store, one bit per frame.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign pos       = (CNT_W'(hand) < n) ? hand : '0;
  assign pos_adv   = next_slot(pos, n);
  assign cur_adv   = next_slot(cur, n);
  assign walk_bit  = rd_data && !rd_zero;

  // Sequencer: clearing pass, references and the eviction walk.
  always_comb begin
    state_next     = state;
    hand_next      = hand;
    fill_done_next = fill_done;
    cur_next       = cur;
    rd_zero_next   = rd_zero;
    mem_we         = 1'b0;
    mem_waddr      = cur[MEM_AW-1:0];
    mem_wdata      = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = cur[MEM_AW-1:0];
    res.valid      = 1'b0;
    res.victim     = FRAME_W'(cur);

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_fire && req.op == OP_REF) begin
          // A reference outside the active frames changes nothing.
          if (int'(req.frame_index) < int'(n)) begin
            mem_we    = 1'b1;
            mem_waddr = req.frame_index[MEM_AW-1:0];
            mem_wdata = 1'b1;
            hand_next = pos;
            if (!fill_done && int'(pos) == int'(req.frame_index)) begin
              hand_next = pos_adv;
              if (pos_adv == '0) begin
                fill_done_next = 1'b1;
              end
            end
          end
        end else if (req_fire) begin
          // Eviction starts by reading the bit under the hand.
          cur_next     = pos;
          mem_re       = 1'b1;
          mem_raddr    = pos[MEM_AW-1:0];
          rd_zero_next = beyond_mem(pos);
          state_next   = ST_WALK;
        end
      end

      ST_WALK: begin
        if (walk_bit) begin
          // Second chance: clear the bit and look at the next frame.
          mem_we       = 1'b1;
          mem_waddr    = cur[MEM_AW-1:0];
          mem_wdata    = 1'b0;
          cur_next     = cur_adv;
          mem_re       = 1'b1;
          mem_raddr    = cur_adv[MEM_AW-1:0];
          // With one frame the read hits the entry being cleared this cycle.
          rd_zero_next = beyond_mem(cur_adv) || (cur_adv == cur);
        end else begin
          res.valid = 1'b1;
          if (res_taken) begin
            hand_next  = cur_adv;
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      hand      <= '0;
      fill_done <= 1'b0;
      clr_addr  <= '0;
    end else begin
      state     <= state_next;
      hand      <= hand_next;
      fill_done <= fill_done_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + MEM_AW'(1);
      end
    end
  end

  // Walk position and read qualifier.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (mem_re) begin
      rd_zero <= rd_zero_next;
    end
  end

  `CPR_ASSERT_NEXT(a_clear_exit, clk, rst, state == ST_CLEAR, state == ST_CLEAR || state == ST_IDLE)
  `CPR_ASSERT_NEXT(a_ref_one_cycle, clk, rst, req_fire && req.op == OP_REF, state == ST_IDLE)
  `CPR_ASSERT_NEXT(a_walk_continues, clk, rst, state == ST_WALK && walk_bit, state == ST_WALK)
  `CPR_ASSERT_NOW(a_no_result_idle, clk, rst, state != ST_WALK, !res.valid)

endmodule

`default_nettype wire

### test/clock_page_replacement_tb.sv
`timescale 1ns / 1ps

module clock_page_replacement_tb import cpr_pkg::*; ();

  localparam int MAX_FRAMES    = MAX_FRAMES_DEFAULT;
  // The longest eviction walks the active frame count plus one frames.
  localparam int SETTLE_CYCLES = MAX_FRAMES + 8;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 125;
  localparam int DIR_ROWS      = 27;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table: either a register write or an item, with an
  // optional victim typed in by hand.
  typedef struct packed {
    row_kind_e                kind;
    logic [FRAME_COUNT_W-1:0] frame_count;
    logic                     op;
    logic [FRAME_W-1:0]       frame;
    bit                       fixed;
    logic [FRAME_W-1:0]       victim;
  } row_t;

  logic clk;
  logic rst;

  cpr_cfg_if cfg ();
  cpr_req_if req ();
  cpr_rsp_if rsp ();

  clock_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp)
  );

  // Predicted state of the clock.
  bit                       ref_bit [MAX_FRAMES];
  int unsigned              clk_hand;
  bit                       fill_seen;
  logic [FRAME_COUNT_W-1:0] frames_reg;

  logic [FRAME_W-1:0] pending_victims [$];
  int unsigned        mismatches;
  int unsigned        victims_seen;
  int unsigned        burst_left;
  bit                 long_hold_done;

  // Directed items: fill-up walk, a full lap, shrinking the clock under the hand,
  // the zero and oversized frame counts, and out-of-range references.
  row_t directed [DIR_ROWS] = '{
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd1,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b0, 8'd0},
    '{ROW_CFG,  9'd4,   OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd3,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd2,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd200, 1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_CFG,  9'd1,   OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd1,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_CFG,  9'd0,   OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_CFG,  9'd511, OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b1, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd128, 1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd1,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd2,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd255, 1'b0, 8'd0},
    '{ROW_CFG,  9'd256, OP_REF,   8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_REF,   8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, 9'd0,   OP_EVICT, 8'd0,   1'b0, 8'd0}
  };

  // Frame count settings for the random phases, extremes included.
  logic [FRAME_COUNT_W-1:0] phase_counts [PHASES-1] = '{
    9'd256, 9'd1, 9'd2, 9'd7, 9'd0, 9'd33, 9'd511, 9'd255, 9'd3, 9'd300
  };

  // Number of frames the clock actually walks.
  function automatic int unsigned frames_in_use();
    int unsigned n;
    n = frames_reg;
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  // Advance the predicted clock by one item; an eviction yields a victim.
  function automatic void second_chance_step(input logic op, input logic [FRAME_W-1:0] idx,
                                             output bit gives, output logic [FRAME_W-1:0] victim);
    int unsigned n;
    int unsigned pos;
    int unsigned cur;
    n = frames_in_use();
    pos = (clk_hand < n) ? clk_hand : 0;
    gives = 1'b0;
    victim = '0;
    if (op == OP_REF) begin
      if (idx < n) begin
        ref_bit[idx] = 1'b1;
        if (!fill_seen && pos == idx) begin
          if (pos + 1 >= n) begin
            fill_seen = 1'b1;
            pos = 0;
          end else begin
            pos = pos + 1;
          end
        end
        clk_hand = pos;
      end
    end else begin
      victim = FRAME_W'(pos);
      for (int unsigned step = 0; step <= n; step++) begin
        cur = pos;
        pos = (pos + 1 >= n) ? 0 : pos + 1;
        if (ref_bit[cur]) begin
          ref_bit[cur] = 1'b0;
        end else begin
          victim = FRAME_W'(cur);
          break;
        end
      end
      clk_hand = pos;
      gives = 1'b1;
    end
  endfunction

  function automatic void note_mismatch(string what, logic [FRAME_W-1:0] exp_v,
                                        logic [FRAME_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected victim %0d, got %0d", $realtime, what, exp_v, got_v);
    end
  endfunction

  // Offer one item, pacing the sender in bursts with gaps between them.
  task automatic paced_request(input logic op, input logic [FRAME_W-1:0] idx, input bit fixed,
                               input logic [FRAME_W-1:0] lit);
    bit                 gives;
    logic [FRAME_W-1:0] pred;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.op <= op;
    req.frame_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    second_chance_step(op, idx, gives, pred);
    if (gives) pending_victims.push_back(fixed ? lit : pred);
    @(negedge clk);
  endtask

  // Let the block go idle before the register is touched.
  task automatic settle_for_config();
    req.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_victims.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [FRAME_COUNT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.frame_count <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    frames_reg = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #(20_000_000);
    $display("clock_page_replacement_tb: FAIL");
    $finish;
  end

  // Receiver: short stalls on its own pattern, long ready stretches, and one long hold.
  initial begin
    rsp.ready = 1'b0;
    long_hold_done = 1'b0;
    @(negedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat (($urandom_range(0, 6) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12))
        @(negedge clk);
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      if (!long_hold_done && victims_seen >= 60) begin
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
    end
  end

  // Check each victim against the oldest one predicted.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      victims_seen++;
      if (pending_victims.size() == 0) begin
        note_mismatch("victim with none pending", 'x, rsp.victim_frame);
      end else if (rsp.victim_frame !== pending_victims[0]) begin
        note_mismatch("wrong victim", pending_victims[0], rsp.victim_frame);
        void'(pending_victims.pop_front());
      end else begin
        void'(pending_victims.pop_front());
      end
    end
  end

  // Stimulus: directed table, then random phases at several frame counts.
  initial begin
    int unsigned        n_act;
    int unsigned        pct_evict;
    int unsigned        waited;
    logic               op;
    logic [FRAME_W-1:0] idx;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = OP_REF;
    req.frame_index = '0;
    cfg.valid = 1'b0;
    cfg.frame_count = '0;
    frames_reg = FRAME_COUNT_RESET;
    clk_hand = 0;
    fill_seen = 1'b0;
    foreach (ref_bit[i]) ref_bit[i] = 1'b0;
    mismatches = 0;
    victims_seen = 0;
    burst_left = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle_for_config();
        write_frame_count(directed[i].frame_count);
      end else begin
        paced_request(directed[i].op, directed[i].frame, directed[i].fixed, directed[i].victim);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_for_config();
      write_frame_count((ph < PHASES - 1) ? phase_counts[ph] : FRAME_COUNT_W'($urandom_range(0,
                        FRAME_COUNT_MAX)));
      n_act = frames_in_use();
      pct_evict = $urandom_range(10, 50);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(0, 99) < pct_evict) ? OP_EVICT : OP_REF;
        // Mostly frames in range; the rest spans the whole field.
        if ($urandom_range(0, 4) != 0) idx = FRAME_W'($urandom_range(0, n_act - 1));
        else idx = FRAME_W'($urandom_range(0, 255));
        paced_request(op, idx, 1'b0, '0);
      end
    end

    // Drain, then watch for stray victims.
    req.valid <= 1'b0;
    waited = 0;
    while (pending_victims.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_victims.size() != 0) begin
      mismatches += pending_victims.size();
      $display("%0t: %0d predicted victims never arrived", $realtime, pending_victims.size());
    end

    if (mismatches == 0) begin
      $display("clock_page_replacement_tb: PASS");
    end else begin
      $display("clock_page_replacement_tb: FAIL");
    end
    $finish;
  end

endmodule
